### design/circle_pair_collision_response_core_macros.svh
// Assertion macros used by the collision response core
`ifndef CIRCLE_PAIR_COLLISION_RESPONSE_CORE_MACROS_SVH
`define CIRCLE_PAIR_COLLISION_RESPONSE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define CRPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRPC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CRPC_ASSERT(label, prop, msg)
`define CRPC_ASSERT_RST(label, prop, msg)
`endif
`endif

### design/crpc_pkg.sv
// Types and constants of the collision response core
package crpc_pkg;
  localparam int FRAC = 14;
  localparam int DIFF_W = 17;
  localparam int DSQ_W = 34;
  localparam int DIST_W = 17;
  localparam int MIN_DIST_W = 11;
  localparam logic [MIN_DIST_W-1:0] MIN_DIST_RESET = 11'd2;

  localparam logic [1:0] OUTCOME_NONE     = 2'd0;
  localparam logic [1:0] OUTCOME_COINCIDE = 2'd1;
  localparam logic [1:0] OUTCOME_SEPARATE = 2'd2;
  localparam logic [1:0] OUTCOME_IMPULSE  = 2'd3;

  typedef struct packed {
    logic signed [15:0] pos_a_x;
    logic signed [15:0] pos_a_y;
    logic signed [15:0] pos_b_x;
    logic signed [15:0] pos_b_y;
    logic signed [15:0] vel_a_x;
    logic signed [15:0] vel_a_y;
    logic signed [15:0] vel_b_x;
    logic signed [15:0] vel_b_y;
    logic [14:0]        radius_a;
    logic [14:0]        radius_b;
    logic [15:0]        mass_a;
    logic [15:0]        mass_b;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] new_pos_a_x;
    logic signed [15:0] new_pos_a_y;
    logic signed [15:0] new_pos_b_x;
    logic signed [15:0] new_pos_b_y;
    logic signed [15:0] new_vel_a_x;
    logic signed [15:0] new_vel_a_y;
    logic signed [15:0] new_vel_b_x;
    logic signed [15:0] new_vel_b_y;
    logic [1:0]         outcome;
  } out_rsp_t;

  // classified request handed from front to back; cls IMPULSE marks contact
  typedef struct packed {
    in_req_t                  req;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [DIST_W-1:0]        cdist;
    logic [1:0]               cls;
  } pair_t;
endpackage

### design/circle_pair_collision_response_core.sv
// Throughput: one request per cycle while neither the front nor the back stalls;
// sqrt and all divider pipelines resolve one bit per stage.
// The front (20 stages) runs until the queue fills; the back (40 stages) holds while
// the output register is occupied and not taken.
// Reset: synchronous, active low; clears all valids and the queue, min_distance returns to 2.
module circle_pair_collision_response_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  crpc_pkg::in_req_t                 in_req,
  output logic                              out_valid,
  input  logic                              out_ready,
  output crpc_pkg::out_rsp_t                out_rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crpc_pkg::MIN_DIST_W-1:0]   cfg_data
);
  import crpc_pkg::*;

  logic [MIN_DIST_W-1:0] min_dist_r;
  logic  front_en, back_en, fr_valid, q_full, q_empty, q_pop;
  pair_t fr_pair, q_pair;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= MIN_DIST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_dist_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign front_en  = !q_full;
  assign in_ready  = front_en;
  assign back_en   = !out_valid || out_ready;
  assign q_pop     = back_en && !q_empty;

  crpc_front u_front (
    .clk, .rst_n, .en(front_en), .in_valid, .in_req, .min_distance(min_dist_r),
    .out_valid(fr_valid), .out_pair(fr_pair)
  );

  crpc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push(fr_valid && front_en), .push_data(fr_pair),
    .pop(q_pop), .pop_data(q_pair), .full(q_full), .empty(q_empty)
  );

  crpc_back u_back (
    .clk, .rst_n, .en(back_en), .in_valid(!q_empty), .in_pair(q_pair),
    .out_valid, .out_rsp
  );
endmodule

### design/crpc_pipe.sv
// Stallable delay line with valid tracking
module crpc_pipe #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         i_valid,
  input  logic [W-1:0] i_data,
  output logic         o_valid,
  output logic [W-1:0] o_data
);
  logic [N-1:0] vld_r;
  logic [W-1:0] dat_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r[0] <= i_valid;
      for (int i = 1; i < N; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat_r[0] <= i_data;
      for (int i = 1; i < N; i++) dat_r[i] <= dat_r[i-1];
    end
  end

  assign o_valid = vld_r[N-1];
  assign o_data  = dat_r[N-1];
endmodule

### design/crpc_isqrt.sv
// Pipelined integer square root, one result bit per stage
module crpc_isqrt #(
  parameter int IW = 34
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IW-1:0]     i_x,
  output logic [IW/2-1:0]   o_root
);
  localparam int RW = IW / 2;
  localparam int MW = RW + 2;

  logic [IW-1:0] x_r [RW];
  logic [MW-1:0] rem_r [RW];
  logic [RW-1:0] root_r [RW];
  logic [IW-1:0] x_in [RW];
  logic [MW-1:0] rem_in [RW];
  logic [RW-1:0] root_in [RW];
  logic [MW+1:0] rem_sh [RW];
  logic [MW+1:0] trial [RW];
  logic [IW-1:0] x_nxt [RW];
  logic [MW-1:0] rem_nxt [RW];
  logic [RW-1:0] root_nxt [RW];

  always_comb begin
    for (int i = 0; i < RW; i++) begin
      if (i == 0) begin
        x_in[i]    = i_x;
        rem_in[i]  = '0;
        root_in[i] = '0;
      end else begin
        x_in[i]    = x_r[i-1];
        rem_in[i]  = rem_r[i-1];
        root_in[i] = root_r[i-1];
      end
      rem_sh[i] = {rem_in[i], x_in[i][IW-1 -: 2]};
      trial[i]  = {2'b00, root_in[i], 2'b01};
      x_nxt[i]  = x_in[i] << 2;
      if (rem_sh[i] >= trial[i]) begin
        rem_nxt[i]  = MW'(rem_sh[i] - trial[i]);
        root_nxt[i] = {root_in[i][RW-2:0], 1'b1};
      end else begin
        rem_nxt[i]  = MW'(rem_sh[i]);
        root_nxt[i] = {root_in[i][RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < RW; i++) begin
        x_r[i]    <= x_nxt[i];
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
      end
    end
  end

  assign o_root = root_r[RW-1];
endmodule

### design/crpc_udiv.sv
// Pipelined restoring unsigned divider, one quotient bit per stage
module crpc_udiv #(
  parameter int NW = 31,
  parameter int DW = 17,
  parameter int QW = 15
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] i_num,
  input  logic [DW-1:0] i_den,
  output logic [QW-1:0] o_quo
);
  localparam int WW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [NW-1:0] rem_in [QW];
  logic [DW-1:0] den_in [QW];
  logic [QW-1:0] quo_in [QW];
  logic [WW-1:0] shd [QW];
  logic [WW-1:0] remw [QW];
  logic [NW-1:0] rem_nxt [QW];
  logic [QW-1:0] quo_nxt [QW];

  always_comb begin
    for (int i = 0; i < QW; i++) begin
      if (i == 0) begin
        rem_in[i] = i_num;
        den_in[i] = i_den;
        quo_in[i] = '0;
      end else begin
        rem_in[i] = rem_r[i-1];
        den_in[i] = den_r[i-1];
        quo_in[i] = quo_r[i-1];
      end
      shd[i]     = WW'(den_in[i]) << (QW - 1 - i);
      remw[i]    = WW'(rem_in[i]);
      quo_nxt[i] = quo_in[i];
      if (remw[i] >= shd[i]) begin
        rem_nxt[i]            = NW'(remw[i] - shd[i]);
        quo_nxt[i][QW-1-i]    = 1'b1;
      end else begin
        rem_nxt[i] = rem_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QW; i++) begin
        rem_r[i] <= rem_nxt[i];
        den_r[i] <= den_in[i];
        quo_r[i] <= quo_nxt[i];
      end
    end
  end

  assign o_quo = quo_r[QW-1];
endmodule

### design/crpc_front.sv
// Front end: centre distance and contact classification
module crpc_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  crpc_pkg::in_req_t                    in_req,
  input  logic [crpc_pkg::MIN_DIST_W-1:0]      min_distance,
  output logic                                 out_valid,
  output crpc_pkg::pair_t                      out_pair
);
  import crpc_pkg::*;

  typedef struct packed {
    in_req_t                  req;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } diff_t;

  typedef struct packed {
    diff_t             d;
    logic [DSQ_W-1:0]  dsq;
  } sq_t;

  diff_t d0n, d0q, d2q;
  sq_t   s1n, s1q;
  pair_t cls_n;
  logic  v0, v1, v2;
  logic  signed [DSQ_W-1:0] sqx, sqy;
  logic  [DIST_W-1:0] root;
  logic  [15:0] rsum;

  always_comb begin
    d0n.req = in_req;
    d0n.dx  = DIFF_W'(in_req.pos_b_x) - DIFF_W'(in_req.pos_a_x);
    d0n.dy  = DIFF_W'(in_req.pos_b_y) - DIFF_W'(in_req.pos_a_y);
  end

  crpc_pipe #(.W($bits(diff_t)), .N(1)) u_p0 (
    .clk, .rst_n, .en, .i_valid(in_valid), .i_data(d0n), .o_valid(v0), .o_data(d0q)
  );

  always_comb begin
    sqx     = d0q.dx * d0q.dx;
    sqy     = d0q.dy * d0q.dy;
    s1n.d   = d0q;
    s1n.dsq = DSQ_W'(sqx + sqy);
  end

  crpc_pipe #(.W($bits(sq_t)), .N(1)) u_p1 (
    .clk, .rst_n, .en, .i_valid(v0), .i_data(s1n), .o_valid(v1), .o_data(s1q)
  );

  crpc_isqrt #(.IW(DSQ_W)) u_sqrt (
    .clk, .en, .i_x(s1q.dsq), .o_root(root)
  );

  crpc_pipe #(.W($bits(diff_t)), .N(DIST_W)) u_p2 (
    .clk, .rst_n, .en, .i_valid(v1), .i_data(s1q.d), .o_valid(v2), .o_data(d2q)
  );

  always_comb begin
    rsum         = 16'(d2q.req.radius_a) + 16'(d2q.req.radius_b);
    cls_n.req    = d2q.req;
    cls_n.dx     = d2q.dx;
    cls_n.dy     = d2q.dy;
    cls_n.cdist  = root;
    if (root <= DIST_W'(min_distance)) begin
      cls_n.cls = OUTCOME_COINCIDE;
    end else if (root >= DIST_W'(rsum)) begin
      cls_n.cls = OUTCOME_NONE;
    end else begin
      cls_n.cls = OUTCOME_IMPULSE;
    end
  end

  crpc_pipe #(.W($bits(pair_t)), .N(1)) u_p3 (
    .clk, .rst_n, .en, .i_valid(v2), .i_data(cls_n), .o_valid(out_valid), .o_data(out_pair)
  );
endmodule

### design/crpc_queue.sv
// Short request queue between front and back
`include "circle_pair_collision_response_core_macros.svh"
module crpc_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  crpc_pkg::pair_t push_data,
  input  logic            pop,
  output crpc_pkg::pair_t pop_data,
  output logic            full,
  output logic            empty
);
  import crpc_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  pair_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);

  `CRPC_ASSERT(a_push_room, push |-> !full, "request pushed into full queue")
  `CRPC_ASSERT(a_pop_data, pop |-> !empty, "request popped from empty queue")
  `CRPC_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "queue count beyond depth")
  `CRPC_ASSERT_RST(a_reset_empty, !rst_n |=> count_r == '0, "queue not empty after reset")
endmodule

### design/crpc_back.sv
// Back end: separation, normal speed and impulse sharing
module crpc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  crpc_pkg::pair_t    in_pair,
  output logic               out_valid,
  output crpc_pkg::out_rsp_t out_rsp
);
  import crpc_pkg::*;

  localparam int NUM1_W = DIFF_W + FRAC;
  localparam int NQ_W   = FRAC + 1;
  localparam int DEN_W  = 17 + FRAC;
  localparam int JQ_W   = 18;
  localparam int JN_W   = 48;
  localparam logic signed [33:0] CBIAS = (34'sd1 <<< (FRAC + 1)) - 34'sd1;
  localparam logic signed [33:0] SBIAS = (34'sd1 <<< FRAC) - 34'sd1;

  typedef struct packed {
    pair_t              p;
    logic signed [15:0] nx, ny;
    logic signed [17:0] ov;
    logic signed [16:0] dvx, dvy;
  } s2_t;

  typedef struct packed {
    pair_t              p;
    logic signed [15:0] nx, ny;
    logic signed [33:0] cpx, cpy;
    logic signed [32:0] spx, spy;
  } s3_t;

  typedef struct packed {
    pair_t              p;
    logic signed [15:0] nx, ny;
    logic signed [17:0] pax, pay, pbx, pby;
    logic signed [20:0] s;
  } s4_t;

  typedef struct packed {
    pair_t              p;
    logic signed [15:0] nx, ny;
    logic signed [17:0] pax, pay, pbx, pby;
    logic               sep;
    logic [33:0]        ja, jb;
    logic [DEN_W-1:0]   den;
  } s5_t;

  typedef struct packed {
    pair_t              p;
    logic signed [17:0] pax, pay, pbx, pby;
    logic               sep;
    logic               nx_neg, ny_neg;
  } s7_t;

  typedef struct packed {
    s7_t              k;
    logic [JN_W-1:0]  nax, nay, nbx, nby;
    logic [DEN_W-1:0] den;
  } s6_t;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) return 16'sh7fff;
    if (v < -20'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [19:0] signed_quo(input logic [JQ_W-1:0] q, input logic neg);
    logic signed [19:0] m;
    m = $signed({2'b00, q});
    return neg ? -m : m;
  endfunction

  pair_t p0q, p1q;
  s2_t   s2n, s2q;
  s3_t   s3n, s3q;
  s4_t   s4n, s4q;
  s5_t   s5n, s5q;
  s6_t   s6n, s6q;
  s7_t   s7q;
  out_rsp_t rn;
  logic  v0, v1, v2, v3, v4, v5, v6, v7;
  logic  [DIFF_W-1:0] adx, ady;
  logic  [NQ_W-1:0] qx, qy;
  logic  [15:0] rsum;
  logic  signed [33:0] cxw, cyw, sum, cb_x, cb_y, sb;
  logic  signed [21:0] jw;
  logic  [JQ_W-1:0] jm;
  logic  [16:0] tot, tote;
  logic  [15:0] wa, wb;
  logic  [14:0] anx, any;
  logic  [JQ_W-1:0] qax, qay, qbx, qby;

  crpc_pipe #(.W($bits(pair_t)), .N(1)) u_p0 (
    .clk, .rst_n, .en, .i_valid(in_valid), .i_data(in_pair), .o_valid(v0), .o_data(p0q)
  );

  assign adx = p0q.dx[DIFF_W-1] ? DIFF_W'(-p0q.dx) : DIFF_W'(p0q.dx);
  assign ady = p0q.dy[DIFF_W-1] ? DIFF_W'(-p0q.dy) : DIFF_W'(p0q.dy);

  crpc_udiv #(.NW(NUM1_W), .DW(DIST_W), .QW(NQ_W)) u_div_nx (
    .clk, .en, .i_num({adx, {FRAC{1'b0}}}), .i_den(p0q.cdist), .o_quo(qx)
  );
  crpc_udiv #(.NW(NUM1_W), .DW(DIST_W), .QW(NQ_W)) u_div_ny (
    .clk, .en, .i_num({ady, {FRAC{1'b0}}}), .i_den(p0q.cdist), .o_quo(qy)
  );
  crpc_pipe #(.W($bits(pair_t)), .N(NQ_W)) u_p1 (
    .clk, .rst_n, .en, .i_valid(v0), .i_data(p0q), .o_valid(v1), .o_data(p1q)
  );

  // contact normal, overlap, relative velocity
  always_comb begin
    rsum    = 16'(p1q.req.radius_a) + 16'(p1q.req.radius_b);
    s2n.p   = p1q;
    s2n.nx  = p1q.dx[DIFF_W-1] ? 16'(-{1'b0, qx}) : 16'({1'b0, qx});
    s2n.ny  = p1q.dy[DIFF_W-1] ? 16'(-{1'b0, qy}) : 16'({1'b0, qy});
    s2n.ov  = $signed({2'b00, rsum}) - $signed({1'b0, p1q.cdist});
    s2n.dvx = 17'(p1q.req.vel_b_x) - 17'(p1q.req.vel_a_x);
    s2n.dvy = 17'(p1q.req.vel_b_y) - 17'(p1q.req.vel_a_y);
  end

  crpc_pipe #(.W($bits(s2_t)), .N(1)) u_p2 (
    .clk, .rst_n, .en, .i_valid(v1), .i_data(s2n), .o_valid(v2), .o_data(s2q)
  );

  always_comb begin
    s3n.p   = s2q.p;
    s3n.nx  = s2q.nx;
    s3n.ny  = s2q.ny;
    s3n.cpx = s2q.nx * s2q.ov;
    s3n.cpy = s2q.ny * s2q.ov;
    s3n.spx = s2q.dvx * s2q.nx;
    s3n.spy = s2q.dvy * s2q.ny;
  end

  crpc_pipe #(.W($bits(s3_t)), .N(1)) u_p3 (
    .clk, .rst_n, .en, .i_valid(v2), .i_data(s3n), .o_valid(v3), .o_data(s3q)
  );

  // shifts round toward zero
  always_comb begin
    cb_x    = s3q.cpx[33] ? CBIAS : 34'sd0;
    cb_y    = s3q.cpy[33] ? CBIAS : 34'sd0;
    cxw     = (s3q.cpx + cb_x) >>> (FRAC + 1);
    cyw     = (s3q.cpy + cb_y) >>> (FRAC + 1);
    sum     = 34'(s3q.spx) + 34'(s3q.spy);
    sb      = sum[33] ? SBIAS : 34'sd0;
    s4n.p   = s3q.p;
    s4n.nx  = s3q.nx;
    s4n.ny  = s3q.ny;
    s4n.pax = 18'(s3q.p.req.pos_a_x) - 18'(cxw);
    s4n.pay = 18'(s3q.p.req.pos_a_y) - 18'(cyw);
    s4n.pbx = 18'(s3q.p.req.pos_b_x) + 18'(cxw);
    s4n.pby = 18'(s3q.p.req.pos_b_y) + 18'(cyw);
    s4n.s   = 21'((sum + sb) >>> FRAC);
  end

  crpc_pipe #(.W($bits(s4_t)), .N(1)) u_p4 (
    .clk, .rst_n, .en, .i_valid(v3), .i_data(s4n), .o_valid(v4), .o_data(s4q)
  );

  // impulse magnitude times mass weight; zero total mass splits evenly
  always_comb begin
    jw  = -(22'(s4q.s) <<< 1);
    jm  = jw[JQ_W-1:0];
    tot = 17'(s4q.p.req.mass_a) + 17'(s4q.p.req.mass_b);
    if (tot == '0) begin
      wa   = 16'd1;
      wb   = 16'd1;
      tote = 17'd2;
    end else begin
      wa   = s4q.p.req.mass_b;
      wb   = s4q.p.req.mass_a;
      tote = tot;
    end
    s5n.p   = s4q.p;
    s5n.nx  = s4q.nx;
    s5n.ny  = s4q.ny;
    s5n.pax = s4q.pax;
    s5n.pay = s4q.pay;
    s5n.pbx = s4q.pbx;
    s5n.pby = s4q.pby;
    s5n.sep = (s4q.s > 0);
    s5n.ja  = 34'(jm) * 34'(wa);
    s5n.jb  = 34'(jm) * 34'(wb);
    s5n.den = {tote, {FRAC{1'b0}}};
  end

  crpc_pipe #(.W($bits(s5_t)), .N(1)) u_p5 (
    .clk, .rst_n, .en, .i_valid(v4), .i_data(s5n), .o_valid(v5), .o_data(s5q)
  );

  always_comb begin
    anx          = s5q.nx[15] ? 15'(-s5q.nx) : 15'(s5q.nx);
    any          = s5q.ny[15] ? 15'(-s5q.ny) : 15'(s5q.ny);
    s6n.k.p      = s5q.p;
    s6n.k.pax    = s5q.pax;
    s6n.k.pay    = s5q.pay;
    s6n.k.pbx    = s5q.pbx;
    s6n.k.pby    = s5q.pby;
    s6n.k.sep    = s5q.sep;
    s6n.k.nx_neg = s5q.nx[15];
    s6n.k.ny_neg = s5q.ny[15];
    s6n.nax      = JN_W'(s5q.ja) * JN_W'(anx);
    s6n.nay      = JN_W'(s5q.ja) * JN_W'(any);
    s6n.nbx      = JN_W'(s5q.jb) * JN_W'(anx);
    s6n.nby      = JN_W'(s5q.jb) * JN_W'(any);
    s6n.den      = s5q.den;
  end

  crpc_pipe #(.W($bits(s6_t)), .N(1)) u_p6 (
    .clk, .rst_n, .en, .i_valid(v5), .i_data(s6n), .o_valid(v6), .o_data(s6q)
  );

  crpc_udiv #(.NW(JN_W), .DW(DEN_W), .QW(JQ_W)) u_div_ax (
    .clk, .en, .i_num(s6q.nax), .i_den(s6q.den), .o_quo(qax)
  );
  crpc_udiv #(.NW(JN_W), .DW(DEN_W), .QW(JQ_W)) u_div_ay (
    .clk, .en, .i_num(s6q.nay), .i_den(s6q.den), .o_quo(qay)
  );
  crpc_udiv #(.NW(JN_W), .DW(DEN_W), .QW(JQ_W)) u_div_bx (
    .clk, .en, .i_num(s6q.nbx), .i_den(s6q.den), .o_quo(qbx)
  );
  crpc_udiv #(.NW(JN_W), .DW(DEN_W), .QW(JQ_W)) u_div_by (
    .clk, .en, .i_num(s6q.nby), .i_den(s6q.den), .o_quo(qby)
  );
  crpc_pipe #(.W($bits(s7_t)), .N(JQ_W)) u_p7 (
    .clk, .rst_n, .en, .i_valid(v6), .i_data(s6q.k), .o_valid(v7), .o_data(s7q)
  );

  always_comb begin
    rn.new_pos_a_x = s7q.p.req.pos_a_x;
    rn.new_pos_a_y = s7q.p.req.pos_a_y;
    rn.new_pos_b_x = s7q.p.req.pos_b_x;
    rn.new_pos_b_y = s7q.p.req.pos_b_y;
    rn.new_vel_a_x = s7q.p.req.vel_a_x;
    rn.new_vel_a_y = s7q.p.req.vel_a_y;
    rn.new_vel_b_x = s7q.p.req.vel_b_x;
    rn.new_vel_b_y = s7q.p.req.vel_b_y;
    rn.outcome     = s7q.p.cls;
    if (s7q.p.cls == OUTCOME_IMPULSE) begin
      rn.new_pos_a_x = sat16(20'(s7q.pax));
      rn.new_pos_a_y = sat16(20'(s7q.pay));
      rn.new_pos_b_x = sat16(20'(s7q.pbx));
      rn.new_pos_b_y = sat16(20'(s7q.pby));
      if (s7q.sep) begin
        rn.outcome = OUTCOME_SEPARATE;
      end else begin
        rn.new_vel_a_x = sat16(20'(s7q.p.req.vel_a_x) - signed_quo(qax, s7q.nx_neg));
        rn.new_vel_a_y = sat16(20'(s7q.p.req.vel_a_y) - signed_quo(qay, s7q.ny_neg));
        rn.new_vel_b_x = sat16(20'(s7q.p.req.vel_b_x) + signed_quo(qbx, s7q.nx_neg));
        rn.new_vel_b_y = sat16(20'(s7q.p.req.vel_b_y) + signed_quo(qby, s7q.ny_neg));
      end
    end
  end

  crpc_pipe #(.W($bits(out_rsp_t)), .N(1)) u_out (
    .clk, .rst_n, .en, .i_valid(v7), .i_data(rn), .o_valid(out_valid), .o_data(out_rsp)
  );
endmodule
